FILE: rtl/pcc_pkg.sv
// ---------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the polygon coplanarity check
// Widths of the fixed-point formats, the vertex classification and the
// entry that travels from the front part to the back part.
// ---------------------------------------------------------------------------
package pcc_pkg;

  // Largest polygon that is reported without error (4 .. 16)
  localparam int VERTEX_LIMIT = 6;

  // Vertex counter saturates at VERTEX_LIMIT+1
  localparam int CNT_W     = $clog2(VERTEX_LIMIT + 2);
  localparam int COUNT_W   = 5;
  localparam int COUNT_MAX = 16;

  // Fixed-point formats
  localparam int COORD_W  = 16;  // Q6.10 nm
  localparam int DIFF_W   = 17;  // 2^-10 nm
  localparam int NORM_W   = 36;  // 2^-20 nm^2
  localparam int PROD_W   = NORM_W + DIFF_W;  // one product
  localparam int ACC_W    = PROD_W + 2;       // sum of up to three products
  localparam int METRIC_W = 51;  // 2^-30 nm^3

  localparam logic [METRIC_W-1:0] THR_RESET = METRIC_W'(10737418);

  // Multiplier steps per vertex kind
  localparam int STEP_W         = 3;
  localparam int N_STEPS_NORMAL = 6;
  localparam int N_STEPS_DOT    = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Role of a vertex inside its polygon
  typedef enum logic [1:0] {
    KIND_REF,     // first vertex: reference point
    KIND_FIRST,   // second vertex: first difference
    KIND_NORMAL,  // third vertex: cross product
    KIND_DOT      // later vertices: triple product
  } vkind_t;

  // Classified vertex handed to the back part
  typedef struct packed {
    vkind_t                         kind;
    logic                           last;
    logic [CNT_W-1:0]               count;  // vertex count including this one
    logic [2:0][DIFF_W-1:0]         diff;   // vertex minus reference, z..x
  } pcc_entry_t;

endpackage

FILE: rtl/polygon_coplanarity_check.sv
// ---------------------------------------------------------------------------
// polygon_coplanarity_check: scalar triple product coplanarity test
// Takes polygon vertices one per transfer and reports, on the last vertex,
// whether all vertices lie in the plane of the first three.
// ---------------------------------------------------------------------------
// Usage
//   Input stream: one vertex per transfer, x/y/z in tdata, tlast on the final
//   vertex of a polygon. Output stream: one result per polygon, sent after
//   its last vertex. cfg_wr_en/cfg_wr_data set the coplanarity threshold; write
//   it only while no polygon is in flight.
//   Vertices are tagged on intake and queued (two entries) in front of the
//   arithmetic unit, which owns a single signed multiplier. The back part
//   sends the first two vertices straight to its finish step; the third
//   takes six cross-product multiplies and every later one three
//   triple-product multiplies, each run followed by an accumulate and a
//   finish step. The next vertex leaves the queue only when the back part
//   is idle again; out_tvalid is set in the finish step of the closing vertex.
//   Reset clears the polygon in progress, empties the queue, drops any
//   pending result and restores the threshold to its reset value.
//   While the receiver stalls, the result is held; a following polygon may
//   be processed up to its own last vertex, then waits, and the queue fills
//   until in_tready falls.
// ---------------------------------------------------------------------------
module polygon_coplanarity_check (
  input  logic                             clk,
  input  logic                             rst_n,
  // Vertex input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // x_coord, y_coord, z_coord
  input  logic                             in_tlast,   // last_vertex
  // Result output
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata,  // is_coplanar, worst_metric,
                                                       // vertex_count, zero fill
  output logic                             out_tuser,  // status
  // Threshold register
  input  logic                             cfg_wr_en,
  input  logic [pcc_pkg::METRIC_W-1:0]     cfg_wr_data
);
  import pcc_pkg::*;

  logic [METRIC_W-1:0] threshold_r;
  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_not_empty;
  pcc_entry_t          q_in;
  pcc_entry_t          q_out;
  logic                res_coplanar;
  logic [METRIC_W-1:0] res_metric;
  logic [COUNT_W-1:0]  res_count;

  // Hold the threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  pcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .x_coord     ($signed(in_tdata[15:0])),
    .y_coord     ($signed(in_tdata[31:16])),
    .z_coord     ($signed(in_tdata[47:32])),
    .last_vertex (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  pcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  pcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_entry      (q_out),
    .q_pop        (q_pop),
    .threshold    (threshold_r),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_coplanar (res_coplanar),
    .res_metric   (res_metric),
    .res_count    (res_count),
    .res_status   (out_tuser)
  );

  // Pack the result fields
  assign out_tdata = {7'b0, res_count, res_metric, res_coplanar};

endmodule

FILE: rtl/pcc_front.sv
// ---------------------------------------------------------------------------
// pcc_front: vertex intake and classification
// Holds the reference point and the vertex counter, forms the difference to
// the reference and tags each vertex with its role in the polygon.
// ---------------------------------------------------------------------------
module pcc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [pcc_pkg::COORD_W-1:0] x_coord,
  input  logic signed [pcc_pkg::COORD_W-1:0] y_coord,
  input  logic signed [pcc_pkg::COORD_W-1:0] z_coord,
  input  logic                            last_vertex,
  input  logic                            q_full,
  output logic                            q_push,
  output pcc_pkg::pcc_entry_t             q_entry
);
  import pcc_pkg::*;

  logic signed [COORD_W-1:0] ref_r [3];
  logic [CNT_W-1:0]          seen_r;
  logic [CNT_W-1:0]          seen_nxt;
  logic [CNT_W-1:0]          count_inc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Count with saturation one above the limit
  assign count_inc = (seen_r < CNT_W'(VERTEX_LIMIT + 1)) ? seen_r + 1'b1 : seen_r;
  assign seen_nxt  = last_vertex ? '0 : count_inc;

  // Classify and form differences
  always_comb begin
    priority if (seen_r == CNT_W'(0)) begin
      q_entry.kind = KIND_REF;
    end else if (seen_r == CNT_W'(1)) begin
      q_entry.kind = KIND_FIRST;
    end else if (seen_r == CNT_W'(2)) begin
      q_entry.kind = KIND_NORMAL;
    end else begin
      q_entry.kind = KIND_DOT;
    end
    q_entry.last    = last_vertex;
    q_entry.count   = count_inc;
    q_entry.diff[0] = DIFF_W'(x_coord) - DIFF_W'(ref_r[0]);
    q_entry.diff[1] = DIFF_W'(y_coord) - DIFF_W'(ref_r[1]);
    q_entry.diff[2] = DIFF_W'(z_coord) - DIFF_W'(ref_r[2]);
  end

  // Advance the counter, capture the reference on the first vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      ref_r[0] <= '0;
      ref_r[1] <= '0;
      ref_r[2] <= '0;
    end else if (q_push) begin
      seen_r <= seen_nxt;
      if (seen_r == CNT_W'(0)) begin
        ref_r[0] <= x_coord;
        ref_r[1] <= y_coord;
        ref_r[2] <= z_coord;
      end
    end
  end

endmodule

FILE: rtl/pcc_queue.sv
// ---------------------------------------------------------------------------
// pcc_queue: short queue of classified vertices
// Decouples the intake from the arithmetic so that either can stall alone.
// ---------------------------------------------------------------------------
module pcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcc_pkg::pcc_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output pcc_pkg::pcc_entry_t pop_data
);
  import pcc_pkg::*;

  pcc_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full      = (fill_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Write entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

FILE: rtl/pcc_back.sv
// ---------------------------------------------------------------------------
// pcc_back: triple-product arithmetic and result formation
// One shared signed multiplier forms the cross product (six products) and
// the triple product (three), accumulating one product per cycle. Keeps the
// running maximum and drives the result register.
// ---------------------------------------------------------------------------
module pcc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  pcc_pkg::pcc_entry_t              q_entry,
  output logic                             q_pop,
  input  logic [pcc_pkg::METRIC_W-1:0]     threshold,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic                             res_coplanar,
  output logic [pcc_pkg::METRIC_W-1:0]     res_metric,
  output logic [pcc_pkg::COUNT_W-1:0]      res_count,
  output logic                             res_status
);
  import pcc_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ACC, B_FIN} bstate_t;

  bstate_t                   state_r;
  pcc_entry_t                cur_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [DIFF_W-1:0]  d0_r   [3];
  logic signed [NORM_W-1:0]  norm_r [3];
  logic signed [PROD_W-1:0]  prod_r;
  logic                      pv_r;
  logic                      pstart_r;
  logic                      pneg_r;
  logic                      pend_r;
  logic [1:0]                ptgt_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [METRIC_W-1:0]       max_r;
  logic                      out_valid_r;
  logic                      out_cop_r;
  logic [METRIC_W-1:0]       out_metric_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_status_r;

  logic signed [NORM_W-1:0]  mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic                      mul_start;
  logic                      mul_neg;
  logic                      mul_end;
  logic [1:0]                mul_tgt;
  logic                      step_last;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [ACC_W-1:0]          mag;
  logic [METRIC_W-1:0]       mag_sat;
  logic [METRIC_W-1:0]       max_nxt;
  logic                      out_free;
  logic                      res_load;
  logic                      err;
  logic                      tri_only;

  assign res_valid    = out_valid_r;
  assign res_coplanar = out_cop_r;
  assign res_metric   = out_metric_r;
  assign res_count    = out_count_r;
  assign res_status   = out_status_r;

  assign q_pop    = (state_r == B_IDLE) && q_valid;
  assign out_free = !out_valid_r || res_ready;
  assign res_load = (state_r == B_FIN) && cur_r.last && out_free;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    mul_neg   = 1'b0;
    mul_end   = 1'b0;
    mul_tgt   = '0;
    if (cur_r.kind == KIND_DOT) begin
      mul_a     = norm_r[step_r[1:0]];
      mul_b     = $signed(cur_r.diff[step_r[1:0]]);
      mul_start = (step_r == STEP_W'(0));
      mul_end   = (step_r == STEP_W'(N_STEPS_DOT - 1));
      step_last = mul_end;
    end else begin
      // Cross product d0 x d, each component a pair of products
      mul_start = !step_r[0];
      mul_neg   = step_r[0];
      mul_end   = step_r[0];
      mul_tgt   = step_r[2:1];
      step_last = (step_r == STEP_W'(N_STEPS_NORMAL - 1));
      unique case (step_r)
        3'd0: begin mul_a = NORM_W'(d0_r[1]); mul_b = $signed(cur_r.diff[2]); end
        3'd1: begin mul_a = NORM_W'(d0_r[2]); mul_b = $signed(cur_r.diff[1]); end
        3'd2: begin mul_a = NORM_W'(d0_r[2]); mul_b = $signed(cur_r.diff[0]); end
        3'd3: begin mul_a = NORM_W'(d0_r[0]); mul_b = $signed(cur_r.diff[2]); end
        3'd4: begin mul_a = NORM_W'(d0_r[0]); mul_b = $signed(cur_r.diff[1]); end
        3'd5: begin mul_a = NORM_W'(d0_r[1]); mul_b = $signed(cur_r.diff[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Accumulate the registered product
  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = (pstart_r ? ACC_W'(0) : acc_r) + (pneg_r ? -prod_ext : prod_ext);

  // Magnitude, saturation and running maximum
  assign mag     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mag_sat = (mag[ACC_W-1:METRIC_W] != '0) ? '1 : mag[METRIC_W-1:0];
  assign max_nxt = ((cur_r.kind == KIND_DOT) && (mag_sat > max_r)) ? mag_sat : max_r;

  // Polygon status
  assign err      = (cur_r.count < CNT_W'(3)) || (cur_r.count > CNT_W'(VERTEX_LIMIT));
  assign tri_only = (cur_r.count == CNT_W'(3));

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      pv_r        <= 1'b0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
      d0_r[0]     <= '0;
      d0_r[1]     <= '0;
      d0_r[2]     <= '0;
      norm_r[0]   <= '0;
      norm_r[1]   <= '0;
      norm_r[2]   <= '0;
    end else begin
      // Drop the result once transferred, unless a new one replaces it
      if (out_valid_r && res_ready && !res_load) begin
        out_valid_r <= 1'b0;
      end

      // Product pipeline: one multiply, then one accumulate
      pv_r <= (state_r == B_MUL);
      if (state_r == B_MUL) begin
        prod_r   <= mul_a * mul_b;
        pstart_r <= mul_start;
        pneg_r   <= mul_neg;
        pend_r   <= mul_end;
        ptgt_r   <= mul_tgt;
      end
      if (pv_r) begin
        acc_r <= acc_nxt;
        if (pend_r && (cur_r.kind == KIND_NORMAL)) begin
          norm_r[ptgt_r] <= acc_nxt[NORM_W-1:0];
        end
      end

      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            cur_r  <= q_entry;
            step_r <= '0;
            if (q_entry.kind == KIND_FIRST) begin
              d0_r[0] <= $signed(q_entry.diff[0]);
              d0_r[1] <= $signed(q_entry.diff[1]);
              d0_r[2] <= $signed(q_entry.diff[2]);
            end
            if ((q_entry.kind == KIND_NORMAL) || (q_entry.kind == KIND_DOT)) begin
              state_r <= B_MUL;
            end else begin
              state_r <= B_FIN;
            end
          end
        end
        B_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_last) begin
            state_r <= B_ACC;
          end
        end
        B_ACC: begin
          state_r <= B_FIN;
        end
        B_FIN: begin
          if (!cur_r.last) begin
            max_r   <= max_nxt;
            state_r <= B_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= err;
            out_count_r  <= (COUNT_W'(cur_r.count) > COUNT_W'(COUNT_MAX))
                            ? COUNT_W'(COUNT_MAX) : COUNT_W'(cur_r.count);
            priority if (err) begin
              out_cop_r    <= 1'b0;
              out_metric_r <= '0;
            end else if (tri_only) begin
              out_cop_r    <= 1'b1;
              out_metric_r <= '0;
            end else begin
              out_cop_r    <= (max_nxt < threshold);
              out_metric_r <= max_nxt;
            end
            max_r   <= '0;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
